FILE: hdl/collision_pair_tracker_2d_defines.svh
// ---------------------------------------------------------------------------
// collision_pair_tracker_2d assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef COLLISION_PAIR_TRACKER_2D_DEFINES_SVH
`define COLLISION_PAIR_TRACKER_2D_DEFINES_SVH

// same-cycle implication
`define CPT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/cpt_pkg.sv
// ---------------------------------------------------------------------------
// cpt_pkg
// Types, widths and helpers shared by the collision pair tracker.
// ---------------------------------------------------------------------------
package cpt_pkg;

   localparam int ID_W    = 6;
   localparam int POS_W   = 24;
   localparam int SIZE_W  = 16;
   localparam int DIFF_W  = 26;              // abs distance, 1/100 px
   localparam int REACH_W = 23;              // (s1+s2)*50
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int RSQ_W   = 2 * REACH_W;

   localparam int MAX_COLLIDERS_DEF = 64;

   typedef enum logic [1:0] {
      CONTACT_NONE  = 2'd0,
      CONTACT_ENTER = 2'd1,
      CONTACT_STAY  = 2'd2,
      CONTACT_EXIT  = 2'd3
   } contact_type;

   typedef struct packed {
      logic [ID_W-1:0]          first_id;
      logic signed [POS_W-1:0]  first_x;
      logic signed [POS_W-1:0]  first_y;
      logic [SIZE_W-1:0]        first_w;
      logic [SIZE_W-1:0]        first_h;
      logic                     first_round;
      logic [ID_W-1:0]          second_id;
      logic signed [POS_W-1:0]  second_x;
      logic signed [POS_W-1:0]  second_y;
      logic [SIZE_W-1:0]        second_w;
      logic [SIZE_W-1:0]        second_h;
      logic                     second_round;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] pair_first;
      logic [ID_W-1:0] pair_second;
      logic            overlap;
      contact_type     contact_event;
   } rsp_type;

   typedef struct packed {
      logic [DIFF_W-1:0]  dx;
      logic [DIFF_W-1:0]  dy;
      logic [REACH_W-1:0] rx;
      logic [REACH_W-1:0] ry;
      logic               both_round;
   } span_type;

   // size * 50: half of the x100 pixel scale, in 1/100 px
   function automatic logic [REACH_W-1:0] scale_half(input logic [SIZE_W:0] s);
      logic [REACH_W-1:0] v;
      v = REACH_W'({s, 5'b0}) + REACH_W'({s, 4'b0}) + REACH_W'({s, 1'b0});
      return v;
   endfunction

endpackage

FILE: hdl/collision_pair_tracker_2d.sv
// ---------------------------------------------------------------------------
// collision_pair_tracker_2d
// Pair intersection test (rect and circle) with per-pair enter/stay/exit
// tracking.
//
//   channel  ports                          moves
//   req      req_valid/req_ready/req_data   one collider pair request
//   rsp      rsp_valid/rsp_ready/rsp_data   ids, overlap, contact event
//
// Four register stages: input, span, products, output.
// One request per cycle sustained while rsp_ready is high and no clearing sweep runs;
// the touching bit is read one stage ahead and bypassed from the write of the request just before it.
// After reset a clearing sweep over 2**(2*IDX_W) entries (4096 at 64 colliders)
// runs with req_ready low.
// A low rsp_ready holds every stage; a free stage still takes the next request.
// ---------------------------------------------------------------------------
`include "collision_pair_tracker_2d_defines.svh"

module collision_pair_tracker_2d #(
   parameter int MAX_COLLIDERS = cpt_pkg::MAX_COLLIDERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cpt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cpt_pkg::rsp_type rsp_data
);

   localparam int IDX_W  = (MAX_COLLIDERS >= 2 ** cpt_pkg::ID_W) ? cpt_pkg::ID_W
                                                                 : $clog2(MAX_COLLIDERS);
   localparam int ADDR_W = 2 * IDX_W;

   // stage valids and readies
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic ready0, ready1, ready2, ready3;
   logic tbl_busy;

   // stage 0
   cpt_pkg::req_type req0_ff;

   // stage 0 -> 1
   cpt_pkg::span_type      span_in;
   logic                   ok_in;
   logic [ADDR_W-1:0]      addr_in;

   // stage 1
   cpt_pkg::span_type      span1_ff;
   logic                   ok1_ff;
   logic [ADDR_W-1:0]      addr1_ff;
   logic [cpt_pkg::ID_W-1:0] a1_ff, b1_ff;

   // stage 1 -> 2
   logic [cpt_pkg::SQ_W-1:0]  dx2_in, dy2_in;
   logic [cpt_pkg::RSQ_W-1:0] r2_in;
   logic                      rect_in;

   // stage 2
   logic [cpt_pkg::SQ_W-1:0]  dx2_ff, dy2_ff;
   logic [cpt_pkg::RSQ_W-1:0] r2_ff;
   logic                      rect_ff, both2_ff, ok2_ff;
   logic [ADDR_W-1:0]         addr2_ff;
   logic [cpt_pkg::ID_W-1:0]  a2_ff, b2_ff;

   // stage 2 -> 3
   logic [cpt_pkg::SQ_W:0]    sq_sum;
   logic                      hit;
   logic                      was_touching;
   cpt_pkg::rsp_type          rsp_in;

   // stage 3
   cpt_pkg::rsp_type          rsp_ff;

   logic tbl_rd_en, tbl_wr_en;

   assign ready3    = !v3_ff || rsp_ready;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign ready0    = !v0_ff || ready1;
   assign req_ready = ready0 && !tbl_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready0) begin
            v0_ff <= req_valid && !tbl_busy;
         end
         if (ready1) begin
            v1_ff <= v0_ff;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // ---- stage 0: input register, then distances
   always_ff @(posedge clock) begin
      if (ready0) begin
         req0_ff <= req_data;
      end
   end

   cpt_span u_span (
      .req_i  (req0_ff),
      .span_o (span_in)
   );

   assign ok_in   = (32'(req0_ff.first_id) < MAX_COLLIDERS) &&
                    (32'(req0_ff.second_id) < MAX_COLLIDERS);
   assign addr_in = {req0_ff.first_id[IDX_W-1:0], req0_ff.second_id[IDX_W-1:0]};

   // ---- stage 1: squares and box test
   always_ff @(posedge clock) begin
      if (ready1) begin
         span1_ff <= span_in;
         ok1_ff   <= ok_in;
         addr1_ff <= addr_in;
         a1_ff    <= req0_ff.first_id;
         b1_ff    <= req0_ff.second_id;
      end
   end

   assign dx2_in  = cpt_pkg::SQ_W'(span1_ff.dx) * cpt_pkg::SQ_W'(span1_ff.dx);
   assign dy2_in  = cpt_pkg::SQ_W'(span1_ff.dy) * cpt_pkg::SQ_W'(span1_ff.dy);
   assign r2_in   = cpt_pkg::RSQ_W'(span1_ff.rx) * cpt_pkg::RSQ_W'(span1_ff.rx);
   assign rect_in = (span1_ff.dx < cpt_pkg::DIFF_W'(span1_ff.rx)) &&
                    (span1_ff.dy < cpt_pkg::DIFF_W'(span1_ff.ry));

   // ---- stage 2: circle compare, touching bit read-modify-write
   always_ff @(posedge clock) begin
      if (ready2) begin
         dx2_ff   <= dx2_in;
         dy2_ff   <= dy2_in;
         r2_ff    <= r2_in;
         rect_ff  <= rect_in;
         both2_ff <= span1_ff.both_round;
         ok2_ff   <= ok1_ff;
         addr2_ff <= addr1_ff;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
      end
   end

   assign tbl_rd_en = ready2 && v1_ff && ok1_ff;
   assign tbl_wr_en = v2_ff && ready3 && ok2_ff;

   cpt_pair_table #(
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tbl_rd_en),
      .rd_addr (addr1_ff),
      .rd_bit  (was_touching),
      .wr_en   (tbl_wr_en),
      .wr_addr (addr2_ff),
      .wr_bit  (hit),
      .busy    (tbl_busy)
   );

   assign sq_sum = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign hit    = both2_ff ? (sq_sum <= (cpt_pkg::SQ_W + 1)'(r2_ff)) : rect_ff;

   always_comb begin
      rsp_in.pair_first  = a2_ff;
      rsp_in.pair_second = b2_ff;
      rsp_in.overlap     = hit;
      rsp_in.contact_event = cpt_pkg::CONTACT_NONE;
      if (ok2_ff) begin
         if (hit) begin
            rsp_in.contact_event = was_touching ? cpt_pkg::CONTACT_STAY
                                                : cpt_pkg::CONTACT_ENTER;
         end else if (was_touching) begin
            rsp_in.contact_event = cpt_pkg::CONTACT_EXIT;
         end
      end
   end

   // ---- stage 3: output register
   always_ff @(posedge clock) begin
      if (ready3) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

   `CPT_ASSERT_NOW(a_clear_blocks, tbl_busy, !req_ready && !tbl_wr_en, "request or write during clear")
   `CPT_ASSERT_NOW(a_enter_stay_hit, rsp_valid && (rsp_data.contact_event == cpt_pkg::CONTACT_ENTER || rsp_data.contact_event == cpt_pkg::CONTACT_STAY), rsp_data.overlap, "enter or stay without overlap")
   `CPT_ASSERT_NOW(a_exit_miss, rsp_valid && rsp_data.contact_event == cpt_pkg::CONTACT_EXIT, !rsp_data.overlap, "exit with overlap")
   `CPT_ASSERT_NEXT(a_stage2_holds, v2_ff && !ready3, v2_ff && $stable(addr2_ff), "stage 2 lost under stall")

endmodule

FILE: hdl/cpt_span.sv
// ---------------------------------------------------------------------------
// cpt_span
// Per-axis absolute center distance and combined reach of one pair.
// ---------------------------------------------------------------------------
module cpt_span (
   input  cpt_pkg::req_type  req_i,
   output cpt_pkg::span_type span_o
);

   localparam int EXT_W = cpt_pkg::DIFF_W + 1;

   logic                             both;
   logic signed [EXT_W-1:0]          x1, x2, y1, y2;
   logic [cpt_pkg::REACH_W-1:0]      ox1, ox2, oy1, oy2;
   logic signed [EXT_W-1:0]          dxs, dys;

   assign both = req_i.first_round & req_i.second_round;

   // circles compare centers, so shift by half the size
   assign ox1 = both ? cpt_pkg::scale_half({1'b0, req_i.first_w})  : '0;
   assign ox2 = both ? cpt_pkg::scale_half({1'b0, req_i.second_w}) : '0;
   assign oy1 = both ? cpt_pkg::scale_half({1'b0, req_i.first_h})  : '0;
   assign oy2 = both ? cpt_pkg::scale_half({1'b0, req_i.second_h}) : '0;

   assign x1 = EXT_W'(req_i.first_x)  + $signed(EXT_W'(ox1));
   assign x2 = EXT_W'(req_i.second_x) + $signed(EXT_W'(ox2));
   assign y1 = EXT_W'(req_i.first_y)  + $signed(EXT_W'(oy1));
   assign y2 = EXT_W'(req_i.second_y) + $signed(EXT_W'(oy2));

   assign dxs = x1 - x2;
   assign dys = y1 - y2;

   always_comb begin
      span_o.dx = dxs[EXT_W-1] ? cpt_pkg::DIFF_W'(-dxs) : cpt_pkg::DIFF_W'(dxs);
      span_o.dy = dys[EXT_W-1] ? cpt_pkg::DIFF_W'(-dys) : cpt_pkg::DIFF_W'(dys);
      span_o.rx = cpt_pkg::scale_half({1'b0, req_i.first_w} + {1'b0, req_i.second_w});
      span_o.ry = cpt_pkg::scale_half({1'b0, req_i.first_h} + {1'b0, req_i.second_h});
      span_o.both_round = both;
   end

endmodule

FILE: hdl/cpt_pair_table.sv
// ---------------------------------------------------------------------------
// cpt_pair_table
// Touching-bit memory: clearing sweep after reset, registered read with
// bypass of the write issued in the same cycle.
// ---------------------------------------------------------------------------
module cpt_pair_table #(
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_bit,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_bit,
   output logic              busy
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic              mem [DEPTH];
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              rd_bit_ff;

   assign clr_addr_in = clr_addr_ff + ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_in;
         if (clr_addr_ff == '1) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_bit_ff <= wr_bit;
         end else begin
            rd_bit_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_bit = rd_bit_ff;
   assign busy   = clr_busy_ff;

endmodule
